/* rtl/lsrs_pkg.sv */
// Shared types and constants of the laser scan range statistics unit.
package lsrs_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int RANGE_BITS  = 16;

	localparam int RNG_W   = 16;
	localparam int IDX_W   = 12;
	localparam int SUM_W   = 28;
	localparam int WIN_W   = 13;
	localparam int ANG_W   = 20;
	localparam int STEP_W  = 17;
	localparam int PROD_W  = STEP_W + IDX_W;
	localparam int BEAR_W  = 30;
	localparam int ACC_W   = 32;
	localparam int CFG_W   = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W   = 17;

	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEPS   = SUM_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam int OUT_FIELDS_W = 4 * RNG_W + 2 * IDX_W + 2 * BEAR_W + 1;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

	localparam logic [RNG_W-1:0] RANGE_MASK =
		(RANGE_BITS >= RNG_W) ? {RNG_W{1'b1}} : RNG_W'((64'd1 << RANGE_BITS) - 64'd1);
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic signed [ACC_W-1:0] BEAR_MAX =
		ACC_W'((64'sd1 <<< (BEAR_W - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] BEAR_MIN = ACC_W'(-(64'sd1 <<< (BEAR_W - 1)));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VALID_LOW  = 3'd0,
		REG_VALID_HIGH = 3'd1,
		REG_WIN_FIRST  = 3'd2,
		REG_WIN_END    = 3'd3,
		REG_THRESHOLD  = 3'd4,
		REG_START_ANG  = 3'd5,
		REG_ANGLE_STEP = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [RNG_W-1:0]        range_low;
		logic [RNG_W-1:0]        range_high;
		logic [WIN_W-1:0]        win_first;
		logic [WIN_W-1:0]        win_end;
		logic [RNG_W-1:0]        threshold;
		logic signed [ANG_W-1:0] start_angle;
		logic [STEP_W-1:0]       angle_step;
	} cfg_t;

	typedef struct packed {
		logic [RNG_W-1:0] min_value;
		logic [IDX_W-1:0] min_pos;
		logic [RNG_W-1:0] max_value;
		logic [IDX_W-1:0] max_pos;
		logic [RNG_W-1:0] win_min;
		logic [SUM_W-1:0] win_sum;
		logic             any_valid;
		logic             win_any_valid;
	} scan_sum_t;

endpackage

/* rtl/lsrs_front.sv */
// Per-sample classification and running scan statistics.
module lsrs_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsrs_pkg::cfg_t                 cfg,
	input  logic [lsrs_pkg::RNG_W-1:0]     sample,
	input  logic                           is_nan,
	input  logic                           last,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           q_full,
	output logic                           push,
	output lsrs_pkg::scan_sum_t            push_data
);
	import lsrs_pkg::*;

	logic [IDX_W-1:0] cnt_q, cnt_n;
	logic [RNG_W-1:0] first_q, first_n;
	logic [RNG_W-1:0] low_q, low_n, high_q, high_n, wlow_q, wlow_n;
	logic [IDX_W-1:0] low_idx_q, low_idx_n, high_idx_q, high_idx_n;
	logic             found_q, found_n, wfound_q, wfound_n;
	logic [SUM_W-1:0] sum_q, sum_n;
	logic [RNG_W-1:0] r;
	logic             valid, in_win, accept;
	logic [SUM_W:0]   sum_add;
	logic [CNT_W-1:0] cnt_inc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && last;

	always_comb begin
		r       = sample & RANGE_MASK;
		valid   = !is_nan && (r >= cfg.range_low) && (r <= cfg.range_high);
		in_win  = ({1'b0, cnt_q} >= cfg.win_first) && ({1'b0, cnt_q} < cfg.win_end);
		first_n = (cnt_q == '0) ? r : first_q;
		low_n = low_q;
		low_idx_n = low_idx_q;
		high_n = high_q;
		high_idx_n = high_idx_q;
		found_n = found_q;
		wlow_n = wlow_q;
		wfound_n = wfound_q;
		sum_n = sum_q;
		sum_add = {1'b0, sum_q} + {{(SUM_W + 1 - RNG_W){1'b0}}, r};
		if (valid) begin
			if (!found_q || r < low_q) begin
				low_n = r;
				low_idx_n = cnt_q;
			end
			if (!found_q || r > high_q) begin
				high_n = r;
				high_idx_n = cnt_q;
			end
			found_n = 1'b1;
		end
		if (in_win) begin
			if (valid) begin
				if (!wfound_q || r < wlow_q) wlow_n = r;
				wfound_n = 1'b1;
			end
			if (!is_nan) sum_n = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
		end
		cnt_inc = {{(CNT_W - IDX_W){1'b0}}, cnt_q} + CNT_W'(1);
		cnt_n   = (cnt_inc >= CNT_W'(MAX_SAMPLES)) ? '0 : cnt_inc[IDX_W-1:0];

		push_data.min_value     = found_n ? low_n : first_n;
		push_data.min_pos       = found_n ? low_idx_n : '0;
		push_data.max_value     = found_n ? high_n : first_n;
		push_data.max_pos       = found_n ? high_idx_n : '0;
		push_data.win_min       = wfound_n ? wlow_n : first_n;
		push_data.win_sum       = sum_n;
		push_data.any_valid     = found_n;
		push_data.win_any_valid = wfound_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			first_q <= '0;
			low_q <= '0;
			low_idx_q <= '0;
			high_q <= '0;
			high_idx_q <= '0;
			found_q <= 1'b0;
			wlow_q <= '0;
			wfound_q <= 1'b0;
			sum_q <= '0;
		end else if (accept) begin
			if (last) begin
				cnt_q <= '0;
				first_q <= '0;
				low_q <= '0;
				low_idx_q <= '0;
				high_q <= '0;
				high_idx_q <= '0;
				found_q <= 1'b0;
				wlow_q <= '0;
				wfound_q <= 1'b0;
				sum_q <= '0;
			end else begin
				cnt_q <= cnt_n;
				first_q <= first_n;
				low_q <= low_n;
				low_idx_q <= low_idx_n;
				high_q <= high_n;
				high_idx_q <= high_idx_n;
				found_q <= found_n;
				wlow_q <= wlow_n;
				wfound_q <= wfound_n;
				sum_q <= sum_n;
			end
		end
	end

endmodule

/* rtl/lsrs_queue.sv */
// Short queue of finished scan summaries between front and back.
module lsrs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lsrs_pkg::scan_sum_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output lsrs_pkg::scan_sum_t head
);
	import lsrs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	scan_sum_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_q, rd_q;
	logic [PTR_W:0]      count_q;

	assign full  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= next_ptr(wr_q);
			if (pop) rd_q <= next_ptr(rd_q);
			if (push && !pop) count_q <= count_q + (PTR_W + 1)'(1);
			else if (pop && !push) count_q <= count_q - (PTR_W + 1)'(1);
		end
	end

endmodule

/* rtl/lsrs_back.sv */
// End-of-scan finishing: mean divide, bearings, obstacle flag, output register.
module lsrs_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsrs_pkg::cfg_t                    cfg,
	input  logic                              q_empty,
	input  lsrs_pkg::scan_sum_t               head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lsrs_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [1:0]                        m_tuser
);
	import lsrs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                state_q;
	logic [SUM_W-1:0]      div_q;
	logic [WIN_W-1:0]      rem_q, divisor_q;
	logic [DIV_CNT_W-1:0]  step_q;
	logic                  zero_div_q;
	logic [PROD_W-1:0]     prod_lo_q, prod_hi_q;
	logic                  tvalid_q;

	logic [WIN_W:0]        rem_sh, rem_sub;
	logic                  ge;
	logic [RNG_W-1:0]      mean;
	logic signed [BEAR_W-1:0] bear_lo, bear_hi;
	logic                  out_free;

	function automatic logic signed [BEAR_W-1:0] sat_bearing(
		input logic signed [ANG_W-1:0] ang,
		input logic [PROD_W-1:0]       prod
	);
		logic signed [ACC_W-1:0] a;
		logic signed [ACC_W-1:0] b;
		a = {{(ACC_W - ANG_W){ang[ANG_W-1]}}, ang} + {{(ACC_W - PROD_W){1'b0}}, prod};
		b = -a;
		if (b > BEAR_MAX) b = BEAR_MAX;
		if (b < BEAR_MIN) b = BEAR_MIN;
		sat_bearing = b[BEAR_W-1:0];
	endfunction

	assign out_free = !tvalid_q || m_tready;
	assign pop      = (state_q == ST_FIN) && out_free;
	assign m_tvalid = tvalid_q;

	always_comb begin
		rem_sh  = {rem_q, div_q[SUM_W-1]};
		rem_sub = rem_sh - {1'b0, divisor_q};
		ge      = rem_sh >= {1'b0, divisor_q};
		if (zero_div_q) mean = '0;
		else if (|div_q[SUM_W-1:RNG_W]) mean = '1;
		else mean = div_q[RNG_W-1:0];
		bear_lo = sat_bearing(cfg.start_angle, prod_lo_q);
		bear_hi = sat_bearing(cfg.start_angle, prod_hi_q);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				div_q <= head.win_sum;
				rem_q <= '0;
				divisor_q <= cfg.win_end - cfg.win_first;
				zero_div_q <= cfg.win_end <= cfg.win_first;
				step_q <= '0;
				prod_lo_q <= PROD_W'(cfg.angle_step) * PROD_W'(head.min_pos);
				prod_hi_q <= PROD_W'(cfg.angle_step) * PROD_W'(head.max_pos);
			end
			ST_DIV: begin
				div_q <= {div_q[SUM_W-2:0], ge};
				rem_q <= ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
				step_q <= step_q + DIV_CNT_W'(1);
			end
			default: ;
		endcase
		if (pop) begin
			m_tdata <= {{OUT_PAD_W{1'b0}},
				(head.win_min < cfg.threshold),
				mean, head.win_min, bear_hi, bear_lo,
				head.max_pos, head.max_value, head.min_pos, head.min_value};
			m_tuser <= {head.win_any_valid, head.any_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (!q_empty) state_q <= ST_DIV;
				ST_DIV:  if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) state_q <= ST_FIN;
				ST_FIN:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (pop) tvalid_q <= 1'b1;
			else if (m_tready) tvalid_q <= 1'b0;
		end
	end

endmodule

/* rtl/laser_scan_range_statistics_unit.sv */
// Top level of the laser scan range statistics unit: config registers and datapath.
//
// Input stream s_*: one range sample per transaction; s_tdata is the range in mm,
// s_tuser flags a missing reading, s_tlast marks the final sample of a scan.
// Output stream m_*: one result transaction per scan, issued after its last sample.
// Config port: cfg_we writes cfg_data into register cfg_index in the same cycle;
// write it only while no scan result is pending.
// Throughput: one sample per cycle, set by the front statistics update. The
// front stalls only when two finished scans are already queued for the back.
// After the last sample is taken its summary is queued; the back then loads the
// divider and the bearing multiplies, runs the bit-serial mean divider and loads
// the output register, which raises m_tvalid. The back finishes one scan before
// it takes the next from the queue, so short scans are limited by the back.
// Reset clears all scan state, the queue and the output valid, and restores the
// register defaults. A stalled receiver holds m_tdata; the back waits, the queue
// fills, and s_tready drops once two scans are waiting.
module laser_scan_range_statistics_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [lsrs_pkg::RNG_W-1:0]            s_tdata,  // sample_range
	input  logic                                  s_tuser,  // sample_is_nan
	input  logic                                  s_tlast,  // last_of_scan
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// min_value, min_position, max_value, max_position, min_bearing, max_bearing,
	// window_minimum, window_mean, obstacle_near, zero fill
	output logic [lsrs_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic [1:0]                            m_tuser,  // any_valid, window_any_valid
	input  logic                                  cfg_we,
	input  logic [lsrs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lsrs_pkg::CFG_W-1:0]            cfg_data
);
	import lsrs_pkg::*;

	cfg_t      cfg_q;
	scan_sum_t push_data, head;
	logic      push, pop, q_full, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low   <= '0;
			cfg_q.range_high  <= '1;
			cfg_q.win_first   <= '0;
			cfg_q.win_end     <= WIN_W'(4096);
			cfg_q.threshold   <= RNG_W'(500);
			cfg_q.start_angle <= '0;
			cfg_q.angle_step  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_VALID_LOW:  cfg_q.range_low   <= cfg_data[RNG_W-1:0];
				REG_VALID_HIGH: cfg_q.range_high  <= cfg_data[RNG_W-1:0];
				REG_WIN_FIRST:  cfg_q.win_first   <= cfg_data[WIN_W-1:0];
				REG_WIN_END:    cfg_q.win_end     <= cfg_data[WIN_W-1:0];
				REG_THRESHOLD:  cfg_q.threshold   <= cfg_data[RNG_W-1:0];
				REG_START_ANG:  cfg_q.start_angle <= cfg_data[ANG_W-1:0];
				REG_ANGLE_STEP: cfg_q.angle_step  <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	lsrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.sample    (s_tdata),
		.is_nan    (s_tuser),
		.last      (s_tlast),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	lsrs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	lsrs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* rtl/lsrs_checker.sv */
// Port-level assertions for the laser scan range statistics unit, with bind.
module lsrs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lsrs_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic [1:0]                        m_tuser
);
	import lsrs_pkg::*;

	logic [RNG_W-1:0] min_value, max_value, win_min;
	logic [IDX_W-1:0] min_pos, max_pos;

	assign min_value = m_tdata[RNG_W-1:0];
	assign min_pos   = m_tdata[RNG_W+IDX_W-1:RNG_W];
	assign max_value = m_tdata[2*RNG_W+IDX_W-1:RNG_W+IDX_W];
	assign max_pos   = m_tdata[2*RNG_W+2*IDX_W-1:2*RNG_W+IDX_W];
	assign win_min   = m_tdata[3*RNG_W+2*IDX_W+2*BEAR_W-1:2*RNG_W+2*IDX_W+2*BEAR_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_none_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> min_pos == '0 && max_pos == '0 && min_value == max_value)
		else $error("empty scan result not taken from first sample");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> min_value <= max_value)
		else $error("scan minimum above maximum");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0] && win_min >= min_value && win_min <= max_value)
		else $error("window minimum outside scan extremes");

endmodule

bind laser_scan_range_statistics_unit lsrs_checker u_lsrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* verif/tb_laser_scan_range_statistics_unit.sv */
// Testbench for the laser scan range statistics unit: random streams checked against a predictor.
`timescale 1ns / 1ps

module tb_laser_scan_range_statistics_unit;
	import lsrs_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [OUT_PAD_W-1:0]    zero_fill;
		logic                    obstacle_near;
		logic [RNG_W-1:0]        window_mean;
		logic [RNG_W-1:0]        window_minimum;
		logic signed [BEAR_W-1:0] max_bearing;
		logic signed [BEAR_W-1:0] min_bearing;
		logic [IDX_W-1:0]        max_position;
		logic [RNG_W-1:0]        max_value;
		logic [IDX_W-1:0]        min_position;
		logic [RNG_W-1:0]        min_value;
	} stats_word_t;

	typedef struct {
		stats_word_t word;
		logic [1:0]  flags;  // any_valid, window_any_valid
	} scan_stats_t;

	class scan_stats_scoreboard;
		cfg_t c;
		logic [IDX_W-1:0] count;
		logic [RNG_W-1:0] first_range, low_range, high_range, win_low;
		logic [IDX_W-1:0] low_idx, high_idx;
		bit seen_valid, win_seen;
		longint win_sum;
		scan_stats_t expected_stats[$];
		int errors, scans, samples;

		function new();
			c = '{range_low: 0, range_high: 16'hFFFF, win_first: 4096, win_end: 4096,
				threshold: 500, start_angle: 0, angle_step: 0};
			c.win_first = 0;
			clear_scan();
			errors = 0;
			scans = 0;
			samples = 0;
		endfunction

		function void clear_scan();
			count = '0;
			first_range = '0;
			low_range = '0;
			high_range = '0;
			win_low = '0;
			low_idx = '0;
			high_idx = '0;
			seen_valid = 0;
			win_seen = 0;
			win_sum = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_VALID_LOW:  c.range_low = v[RNG_W-1:0];
				REG_VALID_HIGH: c.range_high = v[RNG_W-1:0];
				REG_WIN_FIRST:  c.win_first = v[WIN_W-1:0];
				REG_WIN_END:    c.win_end = v[WIN_W-1:0];
				REG_THRESHOLD:  c.threshold = v[RNG_W-1:0];
				REG_START_ANG:  c.start_angle = v[ANG_W-1:0];
				REG_ANGLE_STEP: c.angle_step = v[STEP_W-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [BEAR_W-1:0] bearing_at(logic [IDX_W-1:0] i);
			longint a;
			a = -(longint'(c.start_angle) + longint'(c.angle_step) * longint'(i));
			if (a > longint'(BEAR_MAX))
				a = longint'(BEAR_MAX);
			if (a < longint'(BEAR_MIN))
				a = longint'(BEAR_MIN);
			return a[BEAR_W-1:0];
		endfunction

		function void note_sample(logic [RNG_W-1:0] r, bit nan, bit last);
			logic [IDX_W-1:0] idx;
			bit valid, in_win;
			scan_stats_t e;
			longint mean;
			idx = count;
			samples++;
			valid = !nan && r >= c.range_low && r <= c.range_high;
			in_win = idx >= c.win_first && idx < c.win_end;
			if (idx == 0)
				first_range = r;
			if (valid) begin
				if (!seen_valid || r < low_range) begin
					low_range = r;
					low_idx = idx;
				end
				if (!seen_valid || r > high_range) begin
					high_range = r;
					high_idx = idx;
				end
				seen_valid = 1;
			end
			if (in_win) begin
				if (valid) begin
					if (!win_seen || r < win_low)
						win_low = r;
					win_seen = 1;
				end
				if (!nan) begin
					win_sum += r;
					if (win_sum > longint'(SUM_MAX))
						win_sum = longint'(SUM_MAX);
				end
			end
			count = (count == MAX_SAMPLES - 1) ? '0 : count + 1'b1;
			if (!last)
				return;

			e.word = '0;
			e.word.min_value = seen_valid ? low_range : first_range;
			e.word.min_position = seen_valid ? low_idx : '0;
			e.word.max_value = seen_valid ? high_range : first_range;
			e.word.max_position = seen_valid ? high_idx : '0;
			e.word.min_bearing = bearing_at(e.word.min_position);
			e.word.max_bearing = bearing_at(e.word.max_position);
			e.word.window_minimum = win_seen ? win_low : first_range;
			mean = 0;
			if (c.win_end > c.win_first) begin
				mean = win_sum / longint'(c.win_end - c.win_first);
				if (mean > 65535)
					mean = 65535;
			end
			e.word.window_mean = mean[RNG_W-1:0];
			e.word.obstacle_near = e.word.window_minimum < c.threshold;
			e.flags = {win_seen, seen_valid};
			expected_stats.push_back(e);
			scans++;
			clear_scan();
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic [1:0] flags);
			scan_stats_t e;
			stats_word_t got;
			if (expected_stats.size() == 0) begin
				$error("result transaction with no scan outstanding");
				errors++;
				return;
			end
			e = expected_stats.pop_front();
			got = data;
			compare_field("min_value", e.word.min_value, got.min_value);
			compare_field("min_position", e.word.min_position, got.min_position);
			compare_field("max_value", e.word.max_value, got.max_value);
			compare_field("max_position", e.word.max_position, got.max_position);
			compare_field("min_bearing", e.word.min_bearing, got.min_bearing);
			compare_field("max_bearing", e.word.max_bearing, got.max_bearing);
			compare_field("window_minimum", e.word.window_minimum, got.window_minimum);
			compare_field("window_mean", e.word.window_mean, got.window_mean);
			compare_field("obstacle_near", e.word.obstacle_near, got.obstacle_near);
			compare_field("zero_fill", e.word.zero_fill, got.zero_fill);
			compare_field("any_valid", e.flags[0], flags[0]);
			compare_field("window_any_valid", e.flags[1], flags[1]);
		endfunction

		function int pending();
			return expected_stats.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [RNG_W-1:0]       s_tdata;   // sample_range
	logic                   s_tuser;   // sample_is_nan
	logic                   s_tlast;   // last_of_scan
	logic                   m_tvalid;
	logic                   m_tready;
	// min_value, min_position, max_value, max_position, min_bearing, max_bearing,
	// window_minimum, window_mean, obstacle_near, zero fill
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [1:0]             m_tuser;   // any_valid, window_any_valid
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	scan_stats_scoreboard sb = new();
	bit no_idle;
	int settings;

	laser_scan_range_statistics_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	function automatic int pick_gap();
		int p;
		if (no_idle)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random stalls, checks every accepted transaction
	initial begin
		int ready_hold;
		ready_hold = 0;
		m_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (ready_hold == 0) begin
				if (no_idle || $urandom_range(0, 99) < 65) begin
					m_tready <= 1'b1;
					ready_hold = $urandom_range(1, 24);
				end else begin
					m_tready <= 1'b0;
					ready_hold = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
						: $urandom_range(8, 40);
				end
			end
			ready_hold--;
			@(posedge clk);
		end
	end

	task automatic send_sample(logic [RNG_W-1:0] r, bit nan, bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= r;
		s_tuser <= nan;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(r, nan, last);
	endtask

	task automatic wait_drain(int settle);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic apply_config(cfg_t c);
		write_reg(REG_VALID_LOW, CFG_W'(c.range_low));
		write_reg(REG_VALID_HIGH, CFG_W'(c.range_high));
		write_reg(REG_WIN_FIRST, CFG_W'(c.win_first));
		write_reg(REG_WIN_END, CFG_W'(c.win_end));
		write_reg(REG_THRESHOLD, CFG_W'(c.threshold));
		write_reg(REG_START_ANG, CFG_W'(c.start_angle));
		write_reg(REG_ANGLE_STEP, CFG_W'(c.angle_step));
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic cfg_t make_cfg(int low, int high, int first, int last_idx, int thr,
		int start, int step);
		cfg_t c;
		c.range_low = low[RNG_W-1:0];
		c.range_high = high[RNG_W-1:0];
		c.win_first = first[WIN_W-1:0];
		c.win_end = last_idx[WIN_W-1:0];
		c.threshold = thr[RNG_W-1:0];
		c.start_angle = start[ANG_W-1:0];
		c.angle_step = step[STEP_W-1:0];
		return c;
	endfunction

	function automatic int rand_angle();
		return int'($urandom_range(0, 524288)) - 262144;
	endfunction

	function automatic cfg_t pick_config(int kind);
		int low, first;
		case (kind)
			0: return make_cfg(0, 65535, 0, 4096, 500, 0, 0);
			2: return make_cfg(65535, 0, 0, 4096, 65535, 262144, 65536);
			3: begin
				first = $urandom_range(10, 40);
				return make_cfg($urandom_range(0, 100), $urandom_range(50000, 65535), first,
					$urandom_range(0, first), 0, rand_angle(), $urandom_range(0, 65536));
			end
			4: begin
				low = $urandom_range(0, 65535);
				return make_cfg(low, low, 4096, 4096, $urandom_range(0, 65535), -262144,
					65536);
			end
			5: begin
				first = $urandom_range(0, 200);
				return make_cfg($urandom_range(0, 2000), $urandom_range(30000, 65535), first,
					first + $urandom_range(0, 300), $urandom_range(0, 65535), rand_angle(),
					$urandom_range(0, 65536));
			end
			6: return make_cfg(0, 65535, 0, 4096, $urandom_range(0, 65535), rand_angle(),
				$urandom_range(0, 65536));
			default: begin
				first = $urandom_range(0, 20);
				return make_cfg($urandom_range(0, 2000), $urandom_range(30000, 65535), first,
					first + $urandom_range(1, 40), $urandom_range(0, 65535), rand_angle(),
					$urandom_range(0, 65536));
			end
		endcase
	endfunction

	function automatic logic [RNG_W-1:0] near(int v);
		v = v + int'($urandom_range(0, 4)) - 2;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[RNG_W-1:0];
	endfunction

	function automatic logic [RNG_W-1:0] pick_range(cfg_t c, logic [RNG_W-1:0] prev);
		int p;
		p = $urandom_range(0, 99);
		if (p < 30)
			return RNG_W'($urandom_range(0, 65535));
		if (p < 45)
			return near(c.range_low);
		if (p < 60)
			return near(c.range_high);
		if (p < 72)
			return near(c.threshold);
		if (p < 80)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return prev;
	endfunction

	function automatic int pick_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return $urandom_range(1, 12);
		if (p < 95)
			return $urandom_range(13, 60);
		return $urandom_range(61, 400);
	endfunction

	task automatic random_scan(int len);
		logic [RNG_W-1:0] r;
		r = RNG_W'($urandom_range(0, 65535));
		for (int k = 0; k < len; k++) begin
			r = pick_range(sb.c, r);
			send_sample(r, $urandom_range(0, 99) < 12, k == len - 1);
		end
	endtask

	initial begin
		int sent_here, len;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		no_idle = 0;
		settings = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extremes, no-valid scan, ties
		send_sample(16'h0000, 0, 1);
		send_sample(16'hFFFF, 1, 1);
		send_sample(16'd700, 0, 0);
		send_sample(16'd200, 0, 0);
		send_sample(16'd200, 0, 0);
		send_sample(16'd50, 1, 0);
		send_sample(16'd900, 0, 0);
		send_sample(16'd900, 0, 1);
		wait_drain(SETTLE_CYCLES);

		// range limits, offset window, negative start angle
		apply_config(make_cfg(100, 60000, 1, 4, 65535, -262144, 65536));
		send_sample(16'd50, 0, 0);
		send_sample(16'd60001, 0, 0);
		send_sample(16'd100, 0, 0);
		send_sample(16'd60000, 0, 0);
		send_sample(16'd5000, 1, 0);
		send_sample(16'd100, 0, 0);
		send_sample(16'd200, 0, 1);
		send_sample(16'd99, 0, 0);
		send_sample(16'd60001, 0, 1);
		wait_drain(SETTLE_CYCLES);

		// empty window
		apply_config(make_cfg(0, 65535, 2, 2, 1000, 262144, 0));
		send_sample(16'd1500, 0, 0);
		send_sample(16'd800, 0, 0);
		send_sample(16'd40000, 0, 1);
		wait_drain(SETTLE_CYCLES);

		for (int ph = 0; ph < 8; ph++) begin
			no_idle = (ph == 6);
			apply_config(pick_config(ph));
			sent_here = 0;
			while (sent_here < 205) begin
				len = pick_len();
				random_scan(len);
				sent_here += len;
				if ($urandom_range(0, 99) < 4)
					wait_drain(1);
			end
			wait_drain(SETTLE_CYCLES);
		end

		if (sb.pending() != 0) begin
			$error("%0d scan results never arrived", sb.pending());
			sb.errors++;
		end
		$display("Checked %0d scans built from %0d samples under %0d register settings.",
			sb.scans, sb.samples, settings);
		$display("Mix of empty, inverted and offset windows, scans with no valid sample.");
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
rtl/lsrs_pkg.sv
rtl/lsrs_front.sv
rtl/lsrs_queue.sv
rtl/lsrs_back.sv
rtl/laser_scan_range_statistics_unit.sv
rtl/lsrs_checker.sv
verif/tb_laser_scan_range_statistics_unit.sv
